// File: hdl/pgcdt_pkg.sv
// Package for the PID gain coordinate descent tuner.
// Holds opcodes, phase codes, config indexes, defaults and small helpers.
// No dependencies.
package pgcdt_pkg;

  localparam int GW = 24;
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 20;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // ceil(2^21 / 3): floor(x * DIV3_RECIP / 2^21) equals floor(x / 3) for 20-bit x.
  localparam logic [MUL_BW-1:0] DIV3_RECIP = 20'd699051;
  localparam int DIV3_SHIFT = 21;

  localparam logic [16:0] LOST_LIMIT = 17'd16384;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [GW-1:0] KP_MIN_D = 24'd0;
  localparam logic [GW-1:0] KP_MAX_D = 24'hFFFFFF;
  localparam logic [GW-1:0] KI_MIN_D = 24'd0;
  localparam logic [GW-1:0] KI_MAX_D = 24'hFFFFFF;
  localparam logic [GW-1:0] KD_MIN_D = 24'd0;
  localparam logic [GW-1:0] KD_MAX_D = 24'hFFFFFF;

  typedef enum logic [2:0] {
    OP_ENABLE  = 3'd0,
    OP_DISABLE = 3'd1,
    OP_RESET   = 3'd2,
    OP_SAMPLE  = 3'd3,
    OP_TICK    = 3'd4,
    OP_RESTORE = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    PH_DIS  = 3'd0,
    PH_IDLE = 3'd1,
    PH_COLL = 3'd2,
    PH_EVAL = 3'd3,
    PH_TEST = 3'd4,
    PH_AR   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    FAIL_NONE    = 2'd0,
    FAIL_TIMEOUT = 2'd1,
    FAIL_LINE    = 2'd2,
    FAIL_WINDOW  = 2'd3
  } fail_t;

  typedef enum logic [2:0] {
    CFG_KP_STEP  = 3'd0,
    CFG_KI_STEP  = 3'd1,
    CFG_KD_STEP  = 3'd2,
    CFG_MIN_IMP  = 3'd3,
    CFG_WINDOW   = 3'd4,
    CFG_TIMEOUT  = 3'd5,
    CFG_LINELOSS = 3'd6
  } cfg_idx_t;

  // Clamp to [lo, hi]; the upper bound wins when lo > hi.
  function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] v,
                                               input logic [GW-1:0] lo,
                                               input logic [GW-1:0] hi);
    logic [GW-1:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

endpackage

// File: hdl/pgcdt_mul.sv
// Shared multiplier of the tuner, with a registered product.
// Depends on nothing but its parameters.
module pgcdt_mul #(
  parameter int AW = 32,
  parameter int BW = 20
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  logic [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {{BW{1'b0}}, a} * {{AW{1'b0}}, b};
  end

  assign p = p_r;

endmodule

// File: hdl/pid_gain_coordinate_descent_tuner.sv
// PID gain coordinate descent tuner, top level.
// Uses pgcdt_pkg and the shared multiplier pgcdt_mul.
//
// Each request carries one opcode: enable, disable, reset, fast sample, supervisor tick or
// restore good gains. Each request yields exactly one result that reports the gains live on
// the controller, whether they were written by this request, the phase, the failure code and
// the number of completed coordinate rounds. Requests are handled one at a time by a small
// sequencer around a single 32x20 multiplier that is shared by the objective (omega_rms/3 by
// reciprocal), the gain perturbation and the improvement test. Simple opcodes go from
// acceptance straight to the result. A tick checks the timers and the window; a tick that
// evaluates a baseline window, or that accepts or rejects a candidate, then runs the
// proposal loop (multiply, check, advance for each attempt) until a perturbation moves a
// gain or all six perturbations clamp back to the current gains. A receiver that holds off
// a waiting result stalls the sequencer in S_DONE. The result sits in an output register,
// so the next request is taken while a result still waits. Configuration writes are
// always accepted and are meant for idle periods.
module pid_gain_coordinate_descent_tuner #(
  parameter logic [23:0] KP_MIN = pgcdt_pkg::KP_MIN_D,
  parameter logic [23:0] KP_MAX = pgcdt_pkg::KP_MAX_D,
  parameter logic [23:0] KI_MIN = pgcdt_pkg::KI_MIN_D,
  parameter logic [23:0] KI_MAX = pgcdt_pkg::KI_MAX_D,
  parameter logic [23:0] KD_MIN = pgcdt_pkg::KD_MIN_D,
  parameter logic [23:0] KD_MAX = pgcdt_pkg::KD_MAX_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_now_us,
  input  logic [23:0] in_start_kp,
  input  logic [23:0] in_start_ki,
  input  logic [23:0] in_start_kd,
  input  logic        in_line_valid,
  input  logic [15:0] in_sample_count,
  input  logic [17:0] in_mean_square_error,
  input  logic [19:0] in_omega_rms,
  input  logic [17:0] in_peak_to_peak,
  input  logic [16:0] in_lost_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_gain_kp,
  output logic [23:0] out_gain_ki,
  output logic [23:0] out_gain_kd,
  output logic        out_gains_written,
  output logic [2:0]  out_phase,
  output logic [1:0]  out_fail_code,
  output logic [15:0] out_rounds_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int GW = pgcdt_pkg::GW;
  localparam int PW = pgcdt_pkg::MUL_PW;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_T1, S_T2, S_T3, S_OBJ_MUL, S_OBJ_SUM,
    S_P_MUL, S_P_CHK, S_ADV, S_AR_MUL, S_AR_CMP, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] step_r [3];
  logic [15:0] min_imp_r;
  logic [31:0] window_r, timeout_r, lineloss_r;

  // Latched request.
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic [GW-1:0] start_r [3];
  logic        line_r;
  logic [15:0] samples_r;
  logic [17:0] mse_r, p2p_r;
  logic [19:0] omega_r;
  logic [16:0] lost_r;

  // Tuner state.
  pgcdt_pkg::phase_t phase_r;
  pgcdt_pkg::fail_t  fail_r;
  logic        cand_flag_r, dir_neg_r, round_imp_r, wrote_r;
  logic [1:0]  coord_r;
  logic [15:0] rounds_r;
  logic [31:0] win_start_r, en_time_r, seen_r, base_r, cand_score_r;
  logic [GW-1:0] baseline_r [3];
  logic [GW-1:0] good_r [3];
  logic [GW-1:0] cur_r [3];
  logic [GW-1:0] cgain_r [3];
  logic [GW-1:0] live_r [3];

  // Sequencer scratch.
  logic [2:0]  att_r;
  logic        adv_last_r, prop_ar_r, gt_r;
  logic [31:0] diff_r;

  // Output register.
  logic        out_valid_r;
  logic [GW-1:0] out_g_r [3];
  logic        out_wr_r;
  logic [2:0]  out_ph_r;
  logic [1:0]  out_fail_r;
  logic [15:0] out_rounds_r;

  // Shared multiplier.
  logic [pgcdt_pkg::MUL_AW-1:0] mul_a;
  logic [pgcdt_pkg::MUL_BW-1:0] mul_b;
  logic [PW-1:0]                mul_p;

  logic [GW-1:0] gmin [3];
  logic [GW-1:0] gmax [3];
  assign gmin[0] = KP_MIN; assign gmin[1] = KI_MIN; assign gmin[2] = KD_MIN;
  assign gmax[0] = KP_MAX; assign gmax[1] = KI_MAX; assign gmax[2] = KD_MAX;

  logic [16:0] factor;
  logic [31:0] ref_score;
  logic [GW-1:0] pert_sat;
  logic [GW-1:0] cand_c [3];
  logic        differs;
  logic [31:0] obj;

  always_comb begin
    factor = dir_neg_r ? (pgcdt_pkg::ONE_Q16 - {1'b0, step_r[coord_r]})
                       : (pgcdt_pkg::ONE_Q16 + {1'b0, step_r[coord_r]});
  end

  assign ref_score = (base_r != 32'd0) ? base_r : {15'd0, pgcdt_pkg::ONE_Q16};

  always_comb begin
    unique case (state_r)
      S_OBJ_MUL: begin
        mul_a = {12'd0, omega_r};
        mul_b = pgcdt_pkg::DIV3_RECIP;
      end
      S_AR_MUL: begin
        mul_a = ref_score;
        mul_b = {4'd0, min_imp_r};
      end
      default: begin
        mul_a = {8'd0, cur_r[coord_r]};
        mul_b = {3'd0, factor};
      end
    endcase
  end

  pgcdt_mul #(
    .AW(pgcdt_pkg::MUL_AW),
    .BW(pgcdt_pkg::MUL_BW)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // Perturbed gain, saturated, then all three gains clamped to their bounds.
  always_comb begin
    pert_sat = (mul_p[PW-1:40] != '0) ? {GW{1'b1}} : mul_p[39:16];
    differs = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cand_c[i] = pgcdt_pkg::clamp_gain((coord_r == 2'(i)) ? pert_sat : cur_r[i],
                                        gmin[i], gmax[i]);
      if (cand_c[i] != cur_r[i]) differs = 1'b1;
    end
  end

  // The sum cannot exceed 32 bits for these field widths.
  assign obj = {14'd0, mse_r} + {12'd0, mul_p[pgcdt_pkg::DIV3_SHIFT +: 20]}
             + {15'd0, p2p_r[17:1]} + {15'd0, lost_r};

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r[0]   <= 16'd6554;
      step_r[1]   <= 16'd6554;
      step_r[2]   <= 16'd6554;
      min_imp_r   <= 16'd3277;
      window_r    <= 32'd5000000;
      timeout_r   <= 32'd300000000;
      lineloss_r  <= 32'd2000000;
      phase_r     <= pgcdt_pkg::PH_DIS;
      fail_r      <= pgcdt_pkg::FAIL_NONE;
      cand_flag_r <= 1'b0;
      dir_neg_r   <= 1'b0;
      round_imp_r <= 1'b0;
      wrote_r     <= 1'b0;
      coord_r     <= 2'd0;
      rounds_r    <= 16'd0;
      win_start_r <= 32'd0;
      en_time_r   <= 32'd0;
      seen_r      <= 32'd0;
      base_r      <= 32'd0;
      cand_score_r <= 32'd0;
      for (int i = 0; i < 3; i++) begin
        baseline_r[i] <= '0;
        good_r[i]     <= '0;
        cur_r[i]      <= '0;
        cgain_r[i]    <= '0;
        live_r[i]     <= '0;
      end
      att_r       <= 3'd0;
      adv_last_r  <= 1'b0;
      prop_ar_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pgcdt_pkg::CFG_KP_STEP:  step_r[0]  <= cfg_data[15:0];
          pgcdt_pkg::CFG_KI_STEP:  step_r[1]  <= cfg_data[15:0];
          pgcdt_pkg::CFG_KD_STEP:  step_r[2]  <= cfg_data[15:0];
          pgcdt_pkg::CFG_MIN_IMP:  min_imp_r  <= cfg_data[15:0];
          pgcdt_pkg::CFG_WINDOW:   window_r   <= cfg_data;
          pgcdt_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data;
          pgcdt_pkg::CFG_LINELOSS: lineloss_r <= cfg_data;
          default: ;
        endcase
      end

      // In S_DONE the output register is refilled instead.
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_opcode;
            now_r      <= in_now_us;
            start_r[0] <= in_start_kp;
            start_r[1] <= in_start_ki;
            start_r[2] <= in_start_kd;
            line_r     <= in_line_valid;
            samples_r  <= in_sample_count;
            mse_r      <= in_mean_square_error;
            omega_r    <= in_omega_rms;
            p2p_r      <= in_peak_to_peak;
            lost_r     <= in_lost_fraction;
            wrote_r    <= 1'b0;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          priority case (op_r)
            pgcdt_pkg::OP_ENABLE: begin
              if (phase_r == pgcdt_pkg::PH_DIS) begin
                for (int i = 0; i < 3; i++) begin
                  baseline_r[i] <= start_r[i];
                  good_r[i]     <= start_r[i];
                  cur_r[i]      <= start_r[i];
                  cgain_r[i]    <= start_r[i];
                  live_r[i]     <= start_r[i];
                end
                coord_r     <= 2'd0;
                dir_neg_r   <= 1'b0;
                rounds_r    <= 16'd0;
                round_imp_r <= 1'b0;
                cand_flag_r <= 1'b0;
                fail_r      <= pgcdt_pkg::FAIL_NONE;
                en_time_r   <= now_r;
                seen_r      <= now_r;
                win_start_r <= now_r;
                phase_r     <= pgcdt_pkg::PH_COLL;
              end
            end
            pgcdt_pkg::OP_DISABLE, pgcdt_pkg::OP_RESET, pgcdt_pkg::OP_RESTORE: begin
              for (int i = 0; i < 3; i++) begin
                cur_r[i]  <= good_r[i];
                live_r[i] <= good_r[i];
              end
              wrote_r <= 1'b1;
              if (op_r != pgcdt_pkg::OP_RESTORE) phase_r <= pgcdt_pkg::PH_DIS;
              if (op_r == pgcdt_pkg::OP_RESET) begin
                for (int i = 0; i < 3; i++) good_r[i] <= baseline_r[i];
                base_r       <= 32'd0;
                cand_score_r <= 32'd0;
                rounds_r     <= 16'd0;
              end
            end
            pgcdt_pkg::OP_SAMPLE: begin
              if ((phase_r == pgcdt_pkg::PH_COLL || phase_r == pgcdt_pkg::PH_TEST) && line_r)
                seen_r <= now_r;
            end
            pgcdt_pkg::OP_TICK: begin
              if (phase_r != pgcdt_pkg::PH_DIS) state_r <= S_T1;
            end
            default: ;
          endcase
        end
        S_T1: begin
          if ((now_r - en_time_r) > timeout_r) begin
            for (int i = 0; i < 3; i++) begin
              cur_r[i]  <= good_r[i];
              live_r[i] <= good_r[i];
            end
            wrote_r <= 1'b1;
            phase_r <= pgcdt_pkg::PH_DIS;
            fail_r  <= pgcdt_pkg::FAIL_TIMEOUT;
            state_r <= S_DONE;
          end else begin
            state_r <= S_T2;
          end
        end
        S_T2: begin
          if ((now_r - seen_r) > lineloss_r) begin
            for (int i = 0; i < 3; i++) begin
              cur_r[i]  <= good_r[i];
              live_r[i] <= good_r[i];
            end
            wrote_r <= 1'b1;
            phase_r <= pgcdt_pkg::PH_DIS;
            fail_r  <= pgcdt_pkg::FAIL_LINE;
            state_r <= S_DONE;
          end else begin
            state_r <= S_T3;
          end
        end
        S_T3: begin
          state_r <= S_DONE;
          priority case (phase_r)
            pgcdt_pkg::PH_IDLE: begin
              cand_flag_r <= 1'b0;
              phase_r     <= pgcdt_pkg::PH_COLL;
              win_start_r <= now_r;
            end
            pgcdt_pkg::PH_COLL, pgcdt_pkg::PH_TEST: begin
              if ((now_r - win_start_r) >= window_r) phase_r <= pgcdt_pkg::PH_EVAL;
            end
            pgcdt_pkg::PH_EVAL: begin
              if (samples_r == 16'd0 || lost_r >= pgcdt_pkg::LOST_LIMIT) begin
                for (int i = 0; i < 3; i++) begin
                  cur_r[i]  <= good_r[i];
                  live_r[i] <= good_r[i];
                end
                wrote_r <= 1'b1;
                phase_r <= pgcdt_pkg::PH_DIS;
                fail_r  <= pgcdt_pkg::FAIL_WINDOW;
              end else begin
                state_r <= S_OBJ_MUL;
              end
            end
            pgcdt_pkg::PH_AR: state_r <= S_AR_MUL;
            default: ;
          endcase
        end
        S_OBJ_MUL: state_r <= S_OBJ_SUM;
        S_OBJ_SUM: begin
          if (!cand_flag_r) begin
            base_r    <= obj;
            att_r     <= 3'd0;
            prop_ar_r <= 1'b0;
            state_r   <= S_P_MUL;
          end else begin
            cand_score_r <= obj;
            phase_r      <= pgcdt_pkg::PH_AR;
            state_r      <= S_DONE;
          end
        end
        S_P_MUL: state_r <= S_P_CHK;
        S_P_CHK: begin
          if (differs) begin
            for (int i = 0; i < 3; i++) begin
              cgain_r[i] <= cand_c[i];
              live_r[i]  <= cand_c[i];
            end
            wrote_r     <= 1'b1;
            cand_flag_r <= 1'b1;
            phase_r     <= pgcdt_pkg::PH_TEST;
            win_start_r <= now_r;
            state_r     <= S_DONE;
          end else begin
            adv_last_r <= (att_r == 3'd5);
            att_r      <= att_r + 3'd1;
            state_r    <= S_ADV;
          end
        end
        S_ADV: begin
          // Step to the next direction, then to the next coordinate.
          if (!dir_neg_r) begin
            dir_neg_r <= 1'b1;
          end else begin
            dir_neg_r <= 1'b0;
            coord_r   <= (coord_r >= 2'd2) ? 2'd0 : coord_r + 2'd1;
            if (coord_r >= 2'd2) begin
              if (rounds_r != 16'hFFFF) rounds_r <= rounds_r + 16'd1;
              if (round_imp_r) begin
                for (int i = 0; i < 3; i++) good_r[i] <= cur_r[i];
              end
              round_imp_r <= 1'b0;
            end
          end
          if (adv_last_r) begin
            // Every perturbation clamped back: the search is exhausted.
            if (prop_ar_r) begin
              for (int i = 0; i < 3; i++) live_r[i] <= cur_r[i];
              wrote_r <= 1'b1;
            end
            phase_r <= pgcdt_pkg::PH_IDLE;
            state_r <= S_DONE;
          end else begin
            state_r <= S_P_MUL;
          end
        end
        S_AR_MUL: begin
          diff_r  <= base_r - cand_score_r;
          gt_r    <= (base_r > cand_score_r);
          state_r <= S_AR_CMP;
        end
        S_AR_CMP: begin
          if (gt_r && ({4'd0, diff_r, 16'd0} > mul_p)) begin
            for (int i = 0; i < 3; i++) cur_r[i] <= cgain_r[i];
            base_r      <= cand_score_r;
            round_imp_r <= 1'b1;
          end
          att_r      <= 3'd0;
          adv_last_r <= 1'b0;
          prop_ar_r  <= 1'b1;
          state_r    <= S_ADV;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < 3; i++) out_g_r[i] <= live_r[i];
            out_wr_r     <= wrote_r;
            out_ph_r     <= phase_r;
            out_fail_r   <= fail_r;
            out_rounds_r <= rounds_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gain_kp       = out_g_r[0];
  assign out_gain_ki       = out_g_r[1];
  assign out_gain_kd       = out_g_r[2];
  assign out_gains_written = out_wr_r;
  assign out_phase         = out_ph_r;
  assign out_fail_code     = out_fail_r;
  assign out_rounds_done   = out_rounds_r;

  // A request is never taken while the previous one is still in progress.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  // The coordinate select never leaves the three gains.
  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    coord_r != 2'd3)
    else $error("coordinate select out of range");

  // A failure always leaves the tuner disabled.
  a_fail_disables: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && fail_r != $past(fail_r) && fail_r != pgcdt_pkg::FAIL_NONE)
      |-> (phase_r == pgcdt_pkg::PH_DIS))
    else $error("failure without disable");

endmodule
